@@ rtl/core/hcb_pkg.sv @@
// ----------------------------------------------------------------------------
// hcb_pkg
// shared widths and defaults of the huffman code builder
// ----------------------------------------------------------------------------
package hcb_pkg;

  localparam int DEF_NUM_SYMBOLS = 16;
  localparam int DEF_WEIGHT_BITS = 16;

  // fixed field widths of the channels
  localparam int SYMBOL_WEIGHT_W = 16;
  localparam int SYMBOL_INDEX_W  = 4;
  localparam int CODE_BITS_W     = 15;
  localparam int CODE_LENGTH_W   = 4;

endpackage

@@ rtl/core/hcb_if.sv @@
// ----------------------------------------------------------------------------
// hcb_if
// valid/ready channels carrying weights in and codes out
// ----------------------------------------------------------------------------
interface hcb_weight_if;
  logic                                 valid;
  logic                                 ready;
  logic [hcb_pkg::SYMBOL_WEIGHT_W-1:0]  symbol_weight;
  logic                                 final_weight;

  modport source (output valid, output symbol_weight, output final_weight, input ready);
  modport sink   (input valid, input symbol_weight, input final_weight, output ready);
endinterface

interface hcb_code_if;
  logic                                valid;
  logic                                ready;
  logic [hcb_pkg::SYMBOL_INDEX_W-1:0]  symbol_index;
  logic [hcb_pkg::CODE_BITS_W-1:0]     code_bits;
  logic [hcb_pkg::CODE_LENGTH_W-1:0]   code_length;
  logic                                final_code;

  modport source (output valid, output symbol_index, output code_bits,
                  output code_length, output final_code, input ready);
  modport sink   (input valid, input symbol_index, input code_bits,
                  input code_length, input final_code, output ready);
endinterface

@@ rtl/core/hcb_ram.sv @@
// ----------------------------------------------------------------------------
// hcb_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module hcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/huffman_code_builder.sv @@
// ----------------------------------------------------------------------------
// huffman_code_builder
// loads a set of symbol weights, builds a huffman tree, emits one code per symbol
// ----------------------------------------------------------------------------
// usage:
//   weights channel: one symbol weight per transaction, in symbol order. the
//   set ends at a transaction with final_weight set, or at the one that loads
//   weight NUM_SYMBOLS. ready is high only while a set is being loaded.
//   codes channel: one transaction per loaded symbol, in index order, with
//   final_code on the last; then the block takes a new set.
// sequence:
//   loading accepts a weight in any cycle in which valid is high. merge k
//   (nodes 0..k-1 scanned) makes one weight ram read per node, drains the read
//   pipeline (last compare, then the empty read pipeline) and writes in two
//   states, ST_WR1 and ST_WR2 (the parent ram has a single write port). the
//   build time is set by the single read port of the weight ram. each code
//   then takes three states per tree level (check, parent ram read, left child
//   ram read), then a last check and the output state, plus the receiver's wait.
// reset: synchronous; the block returns to loading an empty set. the rams need
//   no clearing, every entry is written before it is read.
// stall: a code is held in its output register until the receiver takes it;
//   the walk for the next symbol starts only after that.
// ----------------------------------------------------------------------------
module huffman_code_builder #(
  parameter int NUM_SYMBOLS = hcb_pkg::DEF_NUM_SYMBOLS,
  parameter int WEIGHT_BITS = hcb_pkg::DEF_WEIGHT_BITS
) (
  input  logic        clk,
  input  logic        rst,
  hcb_weight_if.sink  weights,
  hcb_code_if.source  codes
);

  // node and counter widths
  localparam int NODE_COUNT = 2 * NUM_SYMBOLS - 1;
  localparam int IW         = $clog2(NODE_COUNT);
  localparam int CW         = $clog2(NUM_SYMBOLS + 1);
  localparam int LEFT_DEPTH = NUM_SYMBOLS - 1;
  localparam int LW         = (LEFT_DEPTH > 1) ? $clog2(LEFT_DEPTH) : 1;
  localparam int EW         = (WEIGHT_BITS < hcb_pkg::SYMBOL_WEIGHT_W) ?
                              WEIGHT_BITS : hcb_pkg::SYMBOL_WEIGHT_W;
  // sums of up to NUM_SYMBOLS weights never overflow
  localparam int SW         = EW + IW;
  localparam int LENW       = (NUM_SYMBOLS > 2) ? $clog2(NUM_SYMBOLS) : 1;

  // sequencer states
  localparam logic [2:0] ST_LOAD    = 3'd0;
  localparam logic [2:0] ST_SCAN    = 3'd1;
  localparam logic [2:0] ST_WR1     = 3'd2;
  localparam logic [2:0] ST_WR2     = 3'd3;
  localparam logic [2:0] ST_EM_CHK  = 3'd4;
  localparam logic [2:0] ST_EM_PAR  = 3'd5;
  localparam logic [2:0] ST_EM_LEFT = 3'd6;
  localparam logic [2:0] ST_EM_OUT  = 3'd7;

  logic [2:0]            state;
  logic [CW-1:0]         loaded;     // weights loaded into the current set
  logic [CW-1:0]         count;      // size of the set being built
  logic [IW-1:0]         k;          // index of the node the current merge creates
  logic [IW-1:0]         scan_idx;   // next node to read in the scan
  logic                  rd_vld;
  logic [IW-1:0]         rd_idx;
  logic                  have1;
  logic                  have2;
  logic [SW-1:0]         w1;
  logic [SW-1:0]         w2;
  logic [IW-1:0]         n1;
  logic [IW-1:0]         n2;
  logic [NODE_COUNT-1:0] merged;     // one flag per node, flops
  logic [CW-1:0]         sym;        // symbol being emitted
  logic [IW-1:0]         pos;        // current node of the walk
  logic [IW-1:0]         par;
  logic [hcb_pkg::CODE_BITS_W-1:0] code;
  logic [LENW-1:0]       len;

  // ram ports
  logic          wt_we;
  logic [IW-1:0] wt_waddr;
  logic [SW-1:0] wt_wdata;
  logic [IW-1:0] wt_raddr;
  logic [SW-1:0] wt_rdata;
  logic          pa_we;
  logic [IW-1:0] pa_waddr;
  logic [IW-1:0] pa_wdata;
  logic [IW-1:0] pa_rdata;
  logic          lc_we;
  logic [LW-1:0] lc_waddr;
  logic [LW-1:0] lc_raddr;
  logic [IW-1:0] lc_rdata;

  logic          load_acc;
  logic          load_last;
  logic [CW-1:0] loaded_inc;
  logic          scan_busy;
  logic          more_merges;   // another merge follows node k
  logic          first_merge;   // a set of loaded_inc weights needs a merge
  logic          cand_ok;
  logic          cand_lt1;
  logic          cand_lt2;

  assign load_acc   = weights.valid && weights.ready;
  assign loaded_inc = loaded + CW'(1);
  assign load_last  = weights.final_weight || (loaded_inc == CW'(NUM_SYMBOLS));
  assign scan_busy  = (scan_idx < k);
  assign more_merges = ((IW + 2)'(k) + (IW + 2)'(2)) < ((IW + 2)'(count) << 1);
  assign first_merge = (loaded_inc > CW'(1));

  // candidate from the scan pipeline
  assign cand_ok  = rd_vld && !merged[rd_idx];
  assign cand_lt1 = !have1 || (wt_rdata < w1);
  assign cand_lt2 = !have2 || (wt_rdata < w2);

  // weight ram: loads, then merged sums
  always_comb begin
    wt_we    = 1'b0;
    wt_waddr = IW'(loaded);
    wt_wdata = SW'(weights.symbol_weight[EW-1:0]);
    if (state == ST_LOAD) begin
      wt_we = load_acc;
    end else if (state == ST_WR1) begin
      wt_we    = 1'b1;
      wt_waddr = k;
      wt_wdata = w1 + w2;
    end
  end
  assign wt_raddr = scan_idx;

  // parent ram: both children of the new node, one per cycle
  assign pa_we    = (state == ST_WR1) || (state == ST_WR2);
  assign pa_waddr = (state == ST_WR1) ? n1 : n2;
  assign pa_wdata = k;

  // left child ram, indexed by merged node number
  assign lc_we    = (state == ST_WR1);
  assign lc_waddr = LW'(k - IW'(count));
  assign lc_raddr = LW'(pa_rdata - IW'(count));

  hcb_ram #(.WIDTH(SW), .DEPTH(NODE_COUNT)) u_weight_ram (
    .clk   (clk),
    .we    (wt_we),
    .waddr (wt_waddr),
    .wdata (wt_wdata),
    .raddr (wt_raddr),
    .rdata (wt_rdata)
  );

  hcb_ram #(.WIDTH(IW), .DEPTH(NODE_COUNT)) u_parent_ram (
    .clk   (clk),
    .we    (pa_we),
    .waddr (pa_waddr),
    .wdata (pa_wdata),
    .raddr (pos),
    .rdata (pa_rdata)
  );

  hcb_ram #(.WIDTH(IW), .DEPTH(LEFT_DEPTH)) u_left_ram (
    .clk   (clk),
    .we    (lc_we),
    .waddr (lc_waddr),
    .wdata (n1),
    .raddr (lc_raddr),
    .rdata (lc_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_LOAD;
      loaded <= '0;
      rd_vld <= 1'b0;
      have1  <= 1'b0;
      have2  <= 1'b0;
      merged <= '0;
    end else begin
      case (state)
        ST_LOAD: begin
          if (load_acc) begin
            if (load_last) begin
              count    <= loaded_inc;
              k        <= IW'(loaded_inc);
              scan_idx <= '0;
              have1    <= 1'b0;
              have2    <= 1'b0;
              merged   <= '0;
              loaded   <= '0;
              sym      <= '0;
              pos      <= '0;
              code     <= '0;
              len      <= '0;
              // a single symbol has no merge at all
              state    <= first_merge ? ST_SCAN : ST_EM_CHK;
            end else begin
              loaded <= loaded_inc;
            end
          end
        end
        ST_SCAN: begin
          // one node read per cycle, its result compared in the next cycle
          rd_vld <= scan_busy;
          rd_idx <= scan_idx;
          if (scan_busy) begin
            scan_idx <= scan_idx + IW'(1);
          end
          if (cand_ok) begin
            if (cand_lt1) begin
              if (have1) begin
                have2 <= 1'b1;
                w2    <= w1;
                n2    <= n1;
              end
              have1 <= 1'b1;
              w1    <= wt_rdata;
              n1    <= rd_idx;
            end else if (cand_lt2) begin
              have2 <= 1'b1;
              w2    <= wt_rdata;
              n2    <= rd_idx;
            end
          end
          if (!scan_busy && !rd_vld) begin
            state <= ST_WR1;
          end
        end
        ST_WR1: begin
          merged[n1] <= 1'b1;
          merged[n2] <= 1'b1;
          state      <= ST_WR2;
        end
        ST_WR2: begin
          have1    <= 1'b0;
          have2    <= 1'b0;
          scan_idx <= '0;
          k        <= k + IW'(1);
          state    <= more_merges ? ST_SCAN : ST_EM_CHK;
        end
        ST_EM_CHK: begin
          // the root is the only unmerged node on the path
          state <= merged[pos] ? ST_EM_PAR : ST_EM_OUT;
        end
        ST_EM_PAR: begin
          par   <= pa_rdata;
          state <= ST_EM_LEFT;
        end
        ST_EM_LEFT: begin
          if (lc_rdata != pos) begin
            code <= code | (hcb_pkg::CODE_BITS_W'(1) << len);
          end
          len   <= len + LENW'(1);
          pos   <= par;
          state <= ST_EM_CHK;
        end
        ST_EM_OUT: begin
          if (codes.ready) begin
            if (sym + CW'(1) == count) begin
              state <= ST_LOAD;
            end else begin
              sym   <= sym + CW'(1);
              pos   <= IW'(sym + CW'(1));
              code  <= '0;
              len   <= '0;
              state <= ST_EM_CHK;
            end
          end
        end
        default: begin
          state <= ST_LOAD;
        end
      endcase
    end
  end

  assign weights.ready      = (state == ST_LOAD);
  assign codes.valid        = (state == ST_EM_OUT);
  assign codes.symbol_index = hcb_pkg::SYMBOL_INDEX_W'(sym);
  assign codes.code_bits    = code;
  assign codes.code_length  = hcb_pkg::CODE_LENGTH_W'(len);
  assign codes.final_code   = (sym + CW'(1) == count);

  // loading and emitting never overlap
  assert property (@(posedge clk) disable iff (rst) !(weights.ready && codes.valid))
    else $error("weights and codes channels active together");

  // a merge always joins two distinct nodes
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_WR1) |-> (have1 && have2 && (n1 != n2)))
    else $error("merge without two distinct nodes");

  // after the last code the block is ready for a new set
  assert property (@(posedge clk) disable iff (rst)
    (codes.valid && codes.ready && codes.final_code) |=> weights.ready)
    else $error("block not back to loading after last code");

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// checks huffman_code_builder: weight sets are driven on the weights channel,
// every code transaction is compared with a local tree builder, with random
// idling on both sides and one long receiver hold-off
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NSYM  = hcb_pkg::DEF_NUM_SYMBOLS;
  localparam int NNODE = 2 * NSYM - 1;
  localparam int WDOG  = 20000;

  typedef struct packed {
    logic [hcb_pkg::SYMBOL_INDEX_W-1:0] symbol_index;
    logic [hcb_pkg::CODE_BITS_W-1:0]    code_bits;
    logic [hcb_pkg::CODE_LENGTH_W-1:0]  code_length;
    logic                               final_code;
  } code_t;

  typedef struct {
    logic [hcb_pkg::SYMBOL_WEIGHT_W-1:0] weight;
    logic                                last;
    logic                                has_exp;   // row carries a typed-in code
    code_t                               exp_code;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #1 clk = ~clk;

  hcb_weight_if weights();
  hcb_code_if   codes();

  huffman_code_builder uut (
    .clk(clk), .rst(rst), .weights(weights), .codes(codes)
  );

  // predictor state: weights of the set being loaded
  logic [63:0] set_weights[NSYM];
  int          set_count;
  code_t       pending_codes[$];
  code_t       typed_codes[$];   // hand-written codes, checked alongside
  int          errors;
  int          idle_cycles;
  int          items_sent;
  bit          stim_done;
  bit          hold_long;

  task automatic report(input string what);
    errors++;
    $display("mismatch @%0t: %s", $time, what);
  endtask

  // huffman build over the loaded set, pushes one code per symbol
  task automatic build_codes();
    logic [63:0] nw[NNODE];
    int          par[NNODE];
    bit          gone[NNODE];
    int          lchild[NNODE];
    int          n, a, b, pos, len, p;
    logic [63:0] code;
    code_t       c;
    n = set_count;
    for (int i = 0; i < NNODE; i++) gone[i] = 0;
    for (int i = 0; i < n; i++) nw[i] = set_weights[i];
    for (int k = n; k + 1 < 2 * n; k++) begin
      a = -1; b = -1;
      // least weight first, lowest index wins ties
      for (int i = 0; i < k; i++) begin
        if (gone[i]) continue;
        if (a < 0 || nw[i] < nw[a]) begin
          b = a; a = i;
        end else if (b < 0 || nw[i] < nw[b]) begin
          b = i;
        end
      end
      nw[k] = nw[a] + nw[b];
      lchild[k] = a;
      par[a] = k; par[b] = k;
      gone[a] = 1; gone[b] = 1;
    end
    for (int s = 0; s < n; s++) begin
      code = 0; len = 0; pos = s;
      while (gone[pos]) begin
        p = par[pos];
        if (lchild[p] != pos) code[len] = 1'b1;
        len++;
        pos = p;
      end
      c.symbol_index = s[hcb_pkg::SYMBOL_INDEX_W-1:0];
      c.code_bits    = code[hcb_pkg::CODE_BITS_W-1:0];
      c.code_length  = len[hcb_pkg::CODE_LENGTH_W-1:0];
      c.final_code   = (s + 1 == n);
      pending_codes.push_back(c);
    end
    set_count = 0;
  endtask

  // one weight transaction, with random lead-in idling; valid stays high
  // after the handshake until the next idle or the end of stimulus
  task automatic send_weight(input logic [hcb_pkg::SYMBOL_WEIGHT_W-1:0] w,
                             input logic fin);
    int gap;
    gap = $urandom_range(0, 5);
    if (gap > 0) begin
      weights.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    weights.valid         <= 1'b1;
    weights.symbol_weight <= w;
    weights.final_weight  <= fin;
    do @(posedge clk); while (!weights.ready);
    set_weights[set_count] = 64'(w);
    set_count++;
    if (fin || set_count == NSYM) build_codes();
  endtask

  task automatic send_set(input int n, input int wmax);
    for (int i = 0; i < n; i++)
      send_weight(16'($urandom_range(0, wmax)), i == n - 1);
  endtask

  // directed table: single symbol, two-symbol tie, extremes, full store
  dir_row_t dir_rows[$];
  initial begin
    // single symbol: code 0, length 0
    dir_rows.push_back('{16'hffff, 1'b1, 1'b1, '{4'd0, 15'd0, 4'd0, 1'b1}});
    // two equal weights: lower index goes left
    dir_rows.push_back('{16'h0000, 1'b0, 1'b1, '{4'd0, 15'd0, 4'd1, 1'b0}});
    dir_rows.push_back('{16'h0000, 1'b1, 1'b1, '{4'd1, 15'd1, 4'd1, 1'b1}});
    // extremes: all-ones against zero
    dir_rows.push_back('{16'hffff, 1'b0, 1'b0, '{default: '0}});
    dir_rows.push_back('{16'h0000, 1'b0, 1'b0, '{default: '0}});
    dir_rows.push_back('{16'h5555, 1'b0, 1'b0, '{default: '0}});
    dir_rows.push_back('{16'haaaa, 1'b1, 1'b0, '{default: '0}});
    // full store with final low: wide sums, ends on weight sixteen
    for (int i = 0; i < NSYM; i++)
      dir_rows.push_back('{16'hffff - 16'(i), 1'b0, 1'b0, '{default: '0}});
  end

  // stimulus
  initial begin
    weights.valid <= 1'b0;
    weights.symbol_weight <= '0;
    weights.final_weight <= 1'b0;
    set_count = 0;
    stim_done = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (dir_rows[i]) begin
      if (dir_rows[i].has_exp) typed_codes.push_back(dir_rows[i].exp_code);
      send_weight(dir_rows[i].weight, dir_rows[i].last);
    end
    // random sets, mostly small, a few full; varied weight ranges for ties
    while (1) begin
      int n, sel, wmax;
      n = ($urandom_range(0, 9) == 0) ? NSYM : $urandom_range(1, 6);
      sel = $urandom_range(0, 3);
      wmax = (sel == 0) ? 3 : (sel == 1) ? 255 : 65535;
      send_set(n, wmax);
      if ($urandom_range(0, 99) < 2) send_weight(16'(~0), 1'b0);
      if (items_sent >= 310) break;
    end
    if (set_count != 0) send_weight(16'($urandom), 1'b1);
    weights.valid <= 1'b0;
    stim_done = 1;
  end

  always @(posedge clk) if (weights.valid && weights.ready) items_sent++;

  // receiver: random stall per code, one long hold-off mid run
  initial begin
    int gap;
    codes.ready <= 1'b0;
    hold_long = 0;
    @(negedge rst);
    while (1) begin
      if (!hold_long && items_sent > 60) begin
        hold_long = 1;
        codes.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
        codes.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      codes.ready <= 1'b1;
      do @(posedge clk); while (!codes.valid);
    end
  end

  // checker
  always @(posedge clk) begin
    code_t got, want;
    if (!rst && codes.valid && codes.ready) begin
      got = '{codes.symbol_index, codes.code_bits, codes.code_length, codes.final_code};
      if (pending_codes.size() == 0) begin
        report($sformatf("unexpected code %p", got));
      end else begin
        want = pending_codes.pop_front();
        if (got.symbol_index !== want.symbol_index)
          report($sformatf("symbol_index %0d want %0d", got.symbol_index,
                           want.symbol_index));
        if (got.code_bits !== want.code_bits)
          report($sformatf("code_bits %h want %h", got.code_bits, want.code_bits));
        if (got.code_length !== want.code_length)
          report($sformatf("code_length %0d want %0d", got.code_length,
                           want.code_length));
        if (got.final_code !== want.final_code)
          report($sformatf("final_code %0b want %0b", got.final_code, want.final_code));
        // typed-in rows must also agree with the predictor
        if (typed_codes.size() != 0) begin
          if (typed_codes.pop_front() !== want) report("directed row disagrees");
        end
      end
    end
  end

  // watchdog: cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (weights.valid && weights.ready) || (codes.valid && codes.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // end of run
  initial begin
    errors = 0;
    idle_cycles = 0;
    items_sent = 0;
    wait (stim_done);
    while (pending_codes.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0 && pending_codes.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
